@@ rtl/core/rmd_pkg.sv @@
// Shared types and codes for the record-marking deframer.
package rmd_pkg;

  localparam int unsigned LEN_W = 31;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] LAST_HDR_IDX = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       frag_end;
    logic       rec_end;
  } result_t;

endpackage

@@ rtl/core/rmd_parse.sv @@
// Fragment header assembly, payload countdown and byte classification.
module rmd_parse
  import rmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] in_byte,
  output result_t    result
);

  logic [23:0]      header_shift;
  logic [23:0]      header_shift_next;
  logic [1:0]       header_byte_count;
  logic [1:0]       header_byte_count_next;
  logic             in_payload;
  logic             in_payload_next;
  logic [LEN_W-1:0] remaining_count;
  logic [LEN_W-1:0] remaining_count_next;
  logic             last_fragment_flag;
  logic             last_fragment_flag_next;
  logic             error_flag;
  logic             error_flag_next;
  logic [31:0]      header;

  assign header = {header_shift, in_byte};

  // Classify the byte and work out the next state
  always_comb begin
    header_shift_next       = header_shift;
    header_byte_count_next  = header_byte_count;
    in_payload_next         = in_payload;
    remaining_count_next    = remaining_count;
    last_fragment_flag_next = last_fragment_flag;
    error_flag_next         = error_flag;
    result.data     = in_byte;
    result.kind     = KIND_HEADER;
    result.frag_end = 1'b0;
    result.rec_end  = 1'b0;

    if (error_flag) begin
      result.kind = KIND_ERROR;
    end else if (in_payload && (remaining_count != '0)) begin
      // Pass payload through and count down
      remaining_count_next = remaining_count - LEN_W'(1);
      result.kind     = KIND_PAYLOAD;
      result.frag_end = (remaining_count == LEN_W'(1));
      result.rec_end  = (remaining_count == LEN_W'(1)) && last_fragment_flag;
      if (remaining_count == LEN_W'(1)) begin
        in_payload_next        = 1'b0;
        header_byte_count_next = '0;
        header_shift_next      = '0;
      end
    end else begin
      in_payload_next = 1'b0;
      if (header_byte_count != LAST_HDR_IDX) begin
        // Collect a leading header byte
        header_shift_next      = {header_shift[15:0], in_byte};
        header_byte_count_next = header_byte_count + 2'd1;
      end else begin
        // Final header byte: decode the full header
        header_shift_next      = '0;
        header_byte_count_next = '0;
        if (header == 32'd0) begin
          error_flag_next = 1'b1;
          result.kind     = KIND_ERROR;
        end else begin
          last_fragment_flag_next = header[31];
          remaining_count_next    = header[LEN_W-1:0];
          if (header[LEN_W-1:0] == '0) begin
            // Empty fragment ends here; it also ends the record if it is the last
            result.frag_end = 1'b1;
            result.rec_end  = header[31];
          end else begin
            in_payload_next = 1'b1;
          end
        end
      end
    end
  end

  // Advance state on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift       <= '0;
      header_byte_count  <= '0;
      in_payload         <= 1'b0;
      remaining_count    <= '0;
      last_fragment_flag <= 1'b0;
      error_flag         <= 1'b0;
    end else if (fire) begin
      header_shift       <= header_shift_next;
      header_byte_count  <= header_byte_count_next;
      in_payload         <= in_payload_next;
      remaining_count    <= remaining_count_next;
      last_fragment_flag <= last_fragment_flag_next;
      error_flag         <= error_flag_next;
    end
  end

endmodule

@@ rtl/core/rmd_out_reg.sv @@
// Result register holding one classified byte for the downstream side.
module rmd_out_reg
  import rmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    result,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [1:0] byte_kind,
  output logic       fragment_end,
  output logic       record_end
);

  result_t held;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign out_byte     = held.data;
  assign byte_kind    = held.kind;
  assign fragment_end = held.frag_end;
  assign record_end   = held.rec_end;

endmodule

@@ rtl/core/record_marking_deframer.sv @@
// Record-marking deframer: splits a byte stream into fragment headers and payload.
// An accepted input byte passes the input register, then the result register.
// Throughput: one byte per cycle while out_stall is low; both registers stall together.
// Reset (rst, synchronous): both registers empty, header assembly restarts, error clears.
// Once an all-zero header is seen every later byte reports an error until reset.
module record_marking_deframer
  import rmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] byte_kind,
  output logic       fragment_end,
  output logic       record_end
);

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       advance;
  result_t    result;

  // Move the held byte forward when the result register has room
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= in_byte;
    end
  end

  rmd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .in_byte (in_reg_byte),
    .result  (result)
  );

  rmd_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .result       (result),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .byte_kind    (byte_kind),
    .fragment_end (fragment_end),
    .record_end   (record_end)
  );

  // Record end only comes with a fragment end
  a_rec_implies_frag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!record_end || fragment_end))
    else $error("record_end without fragment_end");

  // Error bytes carry no end flags
  a_error_no_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (byte_kind == KIND_ERROR)) |-> (!fragment_end && !record_end))
    else $error("error byte carries end flags");

  // Error is sticky across transactions
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && (byte_kind == KIND_ERROR))
      |=> (!out_valid || (byte_kind == KIND_ERROR)))
    else $error("error state left before reset");

  // Input stalls only when the result register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && in_reg_valid))
    else $error("input stalled without downstream backpressure");

endmodule

@@ test/tb_record_marking_deframer.sv @@
// Testbench for record_marking_deframer: byte stream stimulus, in-bench predictor, scoreboard.
`timescale 1ns / 1ps

module tb_record_marking_deframer;
  import rmd_pkg::*;

  localparam int unsigned RAND_BYTES     = 180;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned DIR_N          = 22;
  localparam int unsigned TBL_N          = 31;

  // row flags: typed expectation or left to the predictor
  localparam logic       TYPED = 1'b1;
  localparam logic       PRED  = 1'b0;
  localparam logic [1:0] NONE  = 2'b00;
  localparam logic [1:0] BOTH  = 2'b11;

  typedef struct packed {
    logic [7:0] b;
    logic       fixed;
    logic [1:0] kind;
    logic       fe;
    logic       re;
  } row_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       fragment_end;
  logic       record_end;

  row_t        drv_row = '0;
  row_t        stim_tbl [0:TBL_N-1];
  row_t        stim_q [$];
  result_t     exp_q [$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // predictor state
  logic [23:0] hdr_acc;
  logic [1:0]  hdr_cnt;
  logic        in_body;
  logic [30:0] body_left;
  logic        frag_is_last;
  logic        sticky_err;

  int unsigned idle_cycles = 0;
  int unsigned fail_count  = 0;
  int unsigned n_in        = 0;
  int unsigned n_out       = 0;
  int unsigned n_frag      = 0;
  int unsigned n_rec       = 0;
  int unsigned n_err       = 0;

  record_marking_deframer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_kind    (byte_kind),
    .fragment_end (fragment_end),
    .record_end   (record_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Classify one stream byte and advance the deframing state.
  task automatic deframe_byte(input logic [7:0] b, output result_t r);
    logic [31:0] hdr;
    r.data     = b;
    r.kind     = KIND_HEADER;
    r.frag_end = 1'b0;
    r.rec_end  = 1'b0;
    if (sticky_err) begin
      r.kind = KIND_ERROR;
    end else if (in_body && body_left != '0) begin
      body_left = body_left - 31'd1;
      r.kind    = KIND_PAYLOAD;
      if (body_left == '0) begin
        r.frag_end = 1'b1;
        r.rec_end  = frag_is_last;
        in_body    = 1'b0;
        hdr_cnt    = '0;
        hdr_acc    = '0;
      end
    end else begin
      in_body = 1'b0;
      if (hdr_cnt != LAST_HDR_IDX) begin
        hdr_acc = {hdr_acc[15:0], b};
        hdr_cnt = hdr_cnt + 2'd1;
      end else begin
        hdr     = {hdr_acc, b};
        hdr_acc = '0;
        hdr_cnt = '0;
        if (hdr == '0) begin
          sticky_err = 1'b1;
          r.kind     = KIND_ERROR;
        end else begin
          frag_is_last = hdr[31];
          body_left    = hdr[30:0];
          if (body_left == '0) begin
            // empty fragment ends on the header itself, and closes the record if it is the last
            r.frag_end = 1'b1;
            r.rec_end  = frag_is_last;
          end else begin
            in_body = 1'b1;
          end
        end
      end
    end
  endtask

  // Compare one result with its expectation, field by field.
  task automatic check_result(input result_t want, input result_t got);
    if (got.data !== want.data) begin
      $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time, want.data, got.data);
      fail_count++;
    end
    if (got.kind !== want.kind) begin
      $display("%0t: byte_kind mismatch, expected %0d, actual %0d", $time, want.kind, got.kind);
      fail_count++;
    end
    if (got.frag_end !== want.frag_end) begin
      $display("%0t: fragment_end mismatch, expected %0b, actual %0b", $time, want.frag_end,
               got.frag_end);
      fail_count++;
    end
    if (got.rec_end !== want.rec_end) begin
      $display("%0t: record_end mismatch, expected %0b, actual %0b", $time, want.rec_end,
               got.rec_end);
      fail_count++;
    end
  endtask

  // Track accepted transactions on both sides and run the watchdog.
  always @(posedge clk) begin : scoreboard
    result_t pred;
    result_t got;
    logic    took;
    if (rst) begin
      hdr_acc      = '0;
      hdr_cnt      = '0;
      in_body      = 1'b0;
      body_left    = '0;
      frag_is_last = 1'b0;
      sticky_err   = 1'b0;
      idle_cycles  = 0;
    end else begin
      took = 1'b0;
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte, pred);
        if (drv_row.fixed) begin
          exp_q.push_back({drv_row.b, drv_row.kind, drv_row.fe, drv_row.re});
        end else begin
          exp_q.push_back(pred);
        end
        n_in++;
        took = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = {out_byte, byte_kind, fragment_end, record_end};
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %03h", $time, got);
          fail_count++;
        end else begin
          check_result(exp_q.pop_front(), got);
        end
        n_out++;
        if (fragment_end) n_frag++;
        if (record_end) n_rec++;
        if (byte_kind == KIND_ERROR) n_err++;
        took = 1'b1;
      end
      if (took) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
          $display("%0t: watchdog, no transaction for %0d cycles, %0d results pending",
                   $time, idle_cycles, exp_q.size());
          $display("record_marking_deframer test failed");
          $finish;
        end
      end
    end
  end

  // Stall the result side at the current rate.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic push_pred(input logic [7:0] b);
    stim_q.push_back({b, PRED, KIND_HEADER, NONE});
  endtask

  task automatic queue_rows(input int unsigned lo, input int unsigned hi);
    for (int unsigned i = lo; i <= hi; i++) stim_q.push_back(stim_tbl[i]);
  endtask

  // Queue one well-formed fragment: header, then random payload.
  task automatic queue_fragment();
    int unsigned pick;
    int unsigned len;
    logic        last;
    logic [31:0] hdr;
    pick = $urandom_range(0, 99);
    last = ($urandom_range(0, 2) == 0);
    if (pick < 8) begin
      len  = 0;
      last = 1'b1;
    end else if (pick < 70) begin
      len = $urandom_range(1, 8);
    end else if (pick < 92) begin
      len = $urandom_range(9, 64);
    end else if (pick < 98) begin
      len = $urandom_range(65, 300);
    end else begin
      len = $urandom_range(301, 1023);
    end
    hdr = {last, len[30:0]};
    push_pred(hdr[31:24]);
    push_pred(hdr[23:16]);
    push_pred(hdr[15:8]);
    push_pred(hdr[7:0]);
    for (int unsigned i = 0; i < len; i++) push_pred(8'($urandom_range(0, 255)));
  endtask

  // Drive every queued byte, with random gaps, holding each until accepted.
  task automatic send_queue();
    row_t s;
    while (stim_q.size() != 0) begin
      s = stim_q.pop_front();
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= s.b;
      drv_row  <= s;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    while (exp_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (stim_q.size() < RAND_BYTES) queue_fragment();
    send_queue();
    drain();
  endtask

  initial begin : stimulus
    stim_tbl = '{
      // length 3, not last; payload checked by the predictor
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h03, TYPED, KIND_HEADER, NONE},
      {8'h00, PRED,  KIND_HEADER, NONE},
      {8'hFF, PRED,  KIND_HEADER, NONE},
      {8'h5A, PRED,  KIND_HEADER, NONE},
      // empty last fragment ends fragment and record on the header
      {8'h80, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, BOTH},
      // one-byte last fragment
      {8'h80, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h01, TYPED, KIND_HEADER, NONE},
      {8'hFF, TYPED, KIND_PAYLOAD, BOTH},
      // two-byte last fragment with extreme payload bytes
      {8'h80, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h02, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_PAYLOAD, NONE},
      {8'hFF, PRED,  KIND_HEADER, NONE},
      // zero header, then sticky error on every byte
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_HEADER, NONE},
      {8'h00, TYPED, KIND_ERROR, NONE},
      {8'hFF, TYPED, KIND_ERROR, NONE},
      {8'h80, TYPED, KIND_ERROR, NONE},
      {8'h00, TYPED, KIND_ERROR, NONE},
      {8'h00, TYPED, KIND_ERROR, NONE},
      {8'h00, TYPED, KIND_ERROR, NONE}
    };

    // hold reset, then release it
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed fragments at full rate
    queue_rows(0, DIR_N - 1);
    send_queue();
    drain();

    // random fragments under each idling pattern
    run_phase(0, 0);
    run_phase(46, 0);
    run_phase(0, 46);
    run_phase(19, 19);

    // close the stream with a zero header; nothing recovers from it
    queue_rows(DIR_N, TBL_N - 1);
    send_queue();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes in, %0d results, %0d fragment ends, %0d record ends",
             n_in, n_out, n_frag, n_rec);
    $display("idling patterns: none, sender gaps, result stalls, both; %0d error bytes at end",
             n_err);
    if (fail_count == 0) begin
      $display("record_marking_deframer test passed");
    end else begin
      $display("record_marking_deframer test failed");
    end
    $finish;
  end

endmodule
